[hdl/sclt_pkg.sv]
// ----------------------------------------------------------------------------
// sclt_pkg
// Shared constants, types and register codes of the sector cache tag block.
// ----------------------------------------------------------------------------
`default_nettype none

package sclt_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_P2 = 1 << SLOT_W;
    localparam int WORD_W  = 32;
    localparam int PADDR_W = 3;
    localparam int REG_W   = PADDR_W - 2;

    localparam logic [WORD_W-1:0] SECTOR_COUNT_RESET = 32'd1760;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [REG_W-1:0]  reg_idx_t;

    localparam reg_idx_t REG_SECTOR_COUNT = reg_idx_t'(0);

    typedef struct packed {
        logic      hit;
        slot_idx_t hit_slot;
        slot_idx_t victim_slot;
    } lookup_t;

    typedef struct packed {
        logic               psel;
        logic               penable;
        logic               pwrite;
        logic [PADDR_W-1:0] paddr;
        word_t              pwdata;
    } apb_req_t;

endpackage

`default_nettype wire

[hdl/sclt_apb.sv]
// ----------------------------------------------------------------------------
// sclt_apb
// Configuration register file: holds the sector count, written and read
// over the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module sclt_apb
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sclt_pkg::apb_req_t req,
    output sclt_pkg::word_t        prdata,
    output logic                   pready,
    output sclt_pkg::word_t        sector_count
);

    sclt_pkg::word_t    sector_count_reg;
    sclt_pkg::word_t    sector_count_next;
    sclt_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign reg_idx = req.paddr[sclt_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = req.psel && req.penable && req.pwrite;

    always_comb
    begin
        sector_count_next = sector_count_reg;
        if (wr_en && (reg_idx == sclt_pkg::REG_SECTOR_COUNT))
        begin
            sector_count_next = req.pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= sclt_pkg::SECTOR_COUNT_RESET;
        end
        else
        begin
            sector_count_reg <= sector_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == sclt_pkg::REG_SECTOR_COUNT)
        begin
            prdata = sector_count_reg;
        end
    end

    assign sector_count = sector_count_reg;

endmodule

`default_nettype wire

[hdl/sclt_lookup.sv]
// ----------------------------------------------------------------------------
// sclt_lookup
// Parallel tag compare and victim selection: lowest invalid slot above
// slot 0, else the oldest stamp through a compare tree, ties to the lower slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sclt_lookup
(
    input  wire sclt_pkg::word_t        blk,
    input  wire logic [sclt_pkg::SLOTS-1:0] slot_valid,
    input  wire sclt_pkg::word_t        slot_tag   [sclt_pkg::SLOTS],
    input  wire sclt_pkg::word_t        slot_stamp [sclt_pkg::SLOTS],
    output sclt_pkg::lookup_t           result
);

    localparam int P2 = sclt_pkg::SLOT_P2;

    sclt_pkg::word_t     node_stamp [2*P2];
    sclt_pkg::slot_idx_t node_idx   [2*P2];
    logic                inv_found;
    sclt_pkg::slot_idx_t inv_idx;
    logic                hit_found;
    sclt_pkg::slot_idx_t hit_idx;

    // tag match, lowest matching slot wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = sclt_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (slot_valid[i] && (slot_tag[i] == blk))
            begin
                hit_found = 1'b1;
                hit_idx   = sclt_pkg::slot_idx_t'(i);
            end
        end
    end

    // lowest invalid slot, slot 0 excluded
    always_comb
    begin
        inv_found = 1'b0;
        inv_idx   = '0;
        for (int i = sclt_pkg::SLOTS - 1; i >= 1; i--)
        begin
            if (!slot_valid[i])
            begin
                inv_found = 1'b1;
                inv_idx   = sclt_pkg::slot_idx_t'(i);
            end
        end
    end

    // oldest stamp: left child holds lower slots and keeps ties; pad loses
    always_comb
    begin
        node_stamp[0] = '0;
        node_idx[0]   = '0;
        for (int i = 0; i < P2; i++)
        begin
            if (i < sclt_pkg::SLOTS)
            begin
                node_stamp[P2 + i] = slot_stamp[i];
            end
            else
            begin
                node_stamp[P2 + i] = '1;
            end
            node_idx[P2 + i] = sclt_pkg::slot_idx_t'(i);
        end
        for (int n = P2 - 1; n >= 1; n--)
        begin
            if (node_stamp[2*n + 1] < node_stamp[2*n])
            begin
                node_stamp[n] = node_stamp[2*n + 1];
                node_idx[n]   = node_idx[2*n + 1];
            end
            else
            begin
                node_stamp[n] = node_stamp[2*n];
                node_idx[n]   = node_idx[2*n];
            end
        end
    end

    assign result.hit         = hit_found;
    assign result.hit_slot    = hit_idx;
    assign result.victim_slot = inv_found ? inv_idx : node_idx[1];

endmodule

`default_nettype wire

[hdl/sector_cache_lru_tags.sv]
// ----------------------------------------------------------------------------
// sector_cache_lru_tags
// Tag and LRU replacement controller for a fully associative sector cache of
// eight slots. Each block_number word yields exactly one result word: accepted,
// hit, slot, and on an eviction the old block. Block 0 or a block at or above
// sector_count is rejected with an all-zero result and no state change. The
// block takes one word per cycle while out_ready is high; a word passes through
// the input register, then the result register, to the outputs. The rate is
// set by the update loop: tag compare, stamp compare tree and slot write are
// combinational between the slot registers, so each word sees the state left
// by the one before it. Write sector_count only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_lru_tags
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sclt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [31:0]                   block_number,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               accepted,
    output logic                               hit,
    output logic [2:0]                         slot,
    output logic                               evicted_valid,
    output logic [31:0]                        evicted_block
);

    localparam int SLOTS = sclt_pkg::SLOTS;

    sclt_pkg::apb_req_t apb_req;
    sclt_pkg::word_t    sector_count;
    sclt_pkg::lookup_t  lk;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    sclt_pkg::word_t    blk_reg;
    sclt_pkg::word_t    blk_next;

    // slot state
    logic [SLOTS-1:0]   slot_valid_reg;
    logic [SLOTS-1:0]   slot_valid_next;
    sclt_pkg::word_t    slot_tag_reg    [SLOTS];
    sclt_pkg::word_t    slot_tag_next   [SLOTS];
    sclt_pkg::word_t    slot_stamp_reg  [SLOTS];
    sclt_pkg::word_t    slot_stamp_next [SLOTS];
    sclt_pkg::word_t    use_counter_reg;
    sclt_pkg::word_t    use_counter_next;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               accepted_reg;
    logic               accepted_next;
    logic               hit_reg;
    logic               hit_next;
    logic [2:0]         slot_reg;
    logic [2:0]         slot_next;
    logic               evicted_valid_reg;
    logic               evicted_valid_next;
    sclt_pkg::word_t    evicted_block_reg;
    sclt_pkg::word_t    evicted_block_next;

    logic               fire;
    logic               in_range;
    sclt_pkg::word_t    stamp_new;

    assign apb_req.psel    = psel;
    assign apb_req.penable = penable;
    assign apb_req.pwrite  = pwrite;
    assign apb_req.paddr   = paddr;
    assign apb_req.pwdata  = pwdata;

    sclt_apb u_apb
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (apb_req),
        .prdata       (prdata),
        .pready       (pready),
        .sector_count (sector_count)
    );

    sclt_lookup u_lookup
    (
        .blk        (blk_reg),
        .slot_valid (slot_valid_reg),
        .slot_tag   (slot_tag_reg),
        .slot_stamp (slot_stamp_reg),
        .result     (lk)
    );

    // advance the held word when the result register is free or being drained
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign in_range  = (blk_reg != '0) && (blk_reg < sector_count);
    assign stamp_new = use_counter_reg + 32'd1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        blk_next      = blk_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            blk_next      = block_number;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        slot_valid_next    = slot_valid_reg;
        slot_tag_next      = slot_tag_reg;
        slot_stamp_next    = slot_stamp_reg;
        use_counter_next   = use_counter_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        accepted_next      = accepted_reg;
        hit_next           = hit_reg;
        slot_next          = slot_reg;
        evicted_valid_next = evicted_valid_reg;
        evicted_block_next = evicted_block_reg;
        if (fire)
        begin
            out_valid_next     = 1'b1;
            accepted_next      = 1'b0;
            hit_next           = 1'b0;
            slot_next          = '0;
            evicted_valid_next = 1'b0;
            evicted_block_next = '0;
            if (in_range)
            begin
                use_counter_next = stamp_new;
                accepted_next    = 1'b1;
                if (lk.hit)
                begin
                    hit_next  = 1'b1;
                    slot_next = 3'(lk.hit_slot);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (sclt_pkg::slot_idx_t'(i) == lk.hit_slot)
                        begin
                            slot_stamp_next[i] = stamp_new;
                        end
                    end
                end
                else
                begin
                    slot_next = 3'(lk.victim_slot);
                    if (slot_valid_reg[lk.victim_slot])
                    begin
                        evicted_valid_next = 1'b1;
                        evicted_block_next = slot_tag_reg[lk.victim_slot];
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (sclt_pkg::slot_idx_t'(i) == lk.victim_slot)
                        begin
                            slot_valid_next[i] = 1'b1;
                            slot_tag_next[i]   = blk_reg;
                            slot_stamp_next[i] = stamp_new;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            slot_valid_reg  <= '0;
            use_counter_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_tag_reg[i]   <= '0;
                slot_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            slot_valid_reg  <= slot_valid_next;
            use_counter_reg <= use_counter_next;
            slot_tag_reg    <= slot_tag_next;
            slot_stamp_reg  <= slot_stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg           <= blk_next;
        accepted_reg      <= accepted_next;
        hit_reg           <= hit_next;
        slot_reg          <= slot_next;
        evicted_valid_reg <= evicted_valid_next;
        evicted_block_reg <= evicted_block_next;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_block = evicted_block_reg;

`ifndef SYNTHESIS
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && evicted_valid_reg))
        else $error("hit result also reports an eviction");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !accepted_reg) |->
            (!hit_reg && !evicted_valid_reg && (slot_reg == 3'd0) &&
             (evicted_block_reg == '0)))
        else $error("rejected word carries nonzero result fields");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(slot_valid_reg) & ~slot_valid_reg) == '0))
        else $error("slot valid bit cleared");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_range) |=> (use_counter_reg == $past(use_counter_reg) + 32'd1))
        else $error("use counter did not advance on an in-range word");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sector cache tag and LRU replacement block.
// A queue-fed driver sends block numbers, a monitor predicts each lookup
// (hit, victim slot, eviction) and checks every result word against it.
// ----------------------------------------------------------------------------

module tb;

    localparam int                 STUCK_LIMIT = 1000;
    localparam int                 POOL_SIZE   = 12;
    localparam sclt_pkg::reg_idx_t REG_UNUSED  = sclt_pkg::reg_idx_t'(1);

    typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_SPARSE} pace_t;

    typedef struct packed {
        logic            accepted;
        logic            hit;
        logic [2:0]      slot;
        logic            evicted_valid;
        sclt_pkg::word_t evicted_block;
    } lookup_result_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [sclt_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [31:0]        block_number  = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic               accepted;
    logic               hit;
    logic [2:0]         slot;
    logic               evicted_valid;
    logic [31:0]        evicted_block;

    // shadow of the tag store and register
    logic            line_valid [sclt_pkg::SLOTS];
    sclt_pkg::word_t line_tag   [sclt_pkg::SLOTS];
    sclt_pkg::word_t line_stamp [sclt_pkg::SLOTS];
    sclt_pkg::word_t access_count;
    sclt_pkg::word_t cfg_sector_count;

    sclt_pkg::word_t pending_blocks [$];
    lookup_result_t  expected_results [$];
    int             words_queued  = 0;
    int             words_sent    = 0;
    int             mismatches    = 0;
    int             stuck_cycles  = 0;
    int             send_wait     = 0;
    int             recv_wait     = 0;
    int             recv_draw;
    pace_t          send_pace     = PACE_STEADY;
    pace_t          recv_pace     = PACE_STEADY;

    sector_cache_lru_tags u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .block_number  (block_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .hit           (hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_block (evicted_block)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_RANDOM: return $urandom_range(0, 16);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Look up one block in the shadow store and update it like the block does.
    function automatic lookup_result_t lookup_sector(input sclt_pkg::word_t blk);
        lookup_result_t res;
        int             i;
        int             victim;
        logic           found;
        res   = '0;
        found = 1'b0;
        if (blk == 0 || blk >= cfg_sector_count)
            return res;
        access_count = access_count + 1;
        res.accepted = 1'b1;
        for (i = 0; i < sclt_pkg::SLOTS; i++)
        begin
            if (!found && line_valid[i] && line_tag[i] == blk)
            begin
                found         = 1'b1;
                line_stamp[i] = access_count;
                res.hit       = 1'b1;
                res.slot      = 3'(i);
            end
        end
        if (found)
            return res;
        // slot 0 is the default; the first empty slot above it wins outright
        victim = 0;
        for (i = 1; i < sclt_pkg::SLOTS; i++)
        begin
            if (!found)
            begin
                if (!line_valid[i])
                begin
                    victim = i;
                    found  = 1'b1;
                end
                else if (line_stamp[i] < line_stamp[victim])
                    victim = i;
            end
        end
        if (line_valid[victim])
        begin
            res.evicted_valid = 1'b1;
            res.evicted_block = line_tag[victim];
        end
        res.slot           = 3'(victim);
        line_tag[victim]   = blk;
        line_stamp[victim] = access_count;
        line_valid[victim] = 1'b1;
        return res;
    endfunction

    task automatic check_field(input string name, input sclt_pkg::word_t want,
                               input sclt_pkg::word_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Send side: hold the word until taken, then idle for the drawn gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_wait <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_wait != 0)
            begin
                in_valid  <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_blocks.size() != 0)
            begin
                in_valid     <= 1'b1;
                block_number <= pending_blocks.pop_front();
                send_wait    <= draw_wait(send_pace);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receive side: stall for a drawn number of cycles after each word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            recv_draw  = draw_wait(recv_pace);
            recv_wait <= recv_draw;
            out_ready <= (recv_draw == 0);
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            out_ready <= (recv_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(lookup_sector(block_number));
                words_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, actual %0h %0h %0h %0h %0h",
                             $time, accepted, hit, slot, evicted_valid, evicted_block);
                    mismatches++;
                end
                else
                begin
                    lookup_result_t want;
                    want = expected_results.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(accepted));
                    check_field("hit", 32'(want.hit), 32'(hit));
                    check_field("slot", 32'(want.slot), 32'(slot));
                    check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid));
                    check_field("evicted_block", want.evicted_block, evicted_block);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic queue_block(input sclt_pkg::word_t blk);
        pending_blocks.push_back(blk);
        words_queued++;
    endtask

    task automatic drain();
        while (words_sent != words_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write a register, then read the sector count back where it was the target.
    task automatic write_reg(input sclt_pkg::reg_idx_t idx, input sclt_pkg::word_t val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == sclt_pkg::REG_SECTOR_COUNT)
        begin
            cfg_sector_count = val;
            @(posedge clk);
            psel  <= 1'b1;
            paddr <= {sclt_pkg::REG_SECTOR_COUNT, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            check_field("prdata", cfg_sector_count, prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    initial
    begin
        sclt_pkg::word_t tag_pool [POOL_SIZE];
        sclt_pkg::word_t count;
        sclt_pkg::word_t blk;
        int    ph;
        int    n;
        int    k;
        int    r;

        for (k = 0; k < sclt_pkg::SLOTS; k++)
        begin
            line_valid[k] = 1'b0;
            line_tag[k]   = '0;
            line_stamp[k] = '0;
        end
        access_count     = '0;
        cfg_sector_count = sclt_pkg::SECTOR_COUNT_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sector count: bounds, fill every slot, hit, then LRU evictions
        queue_block(32'd0);
        queue_block(32'd1760);
        queue_block(32'd1759);
        for (k = 1; k <= 7; k++)
            queue_block(sclt_pkg::word_t'(k));
        queue_block(32'd1759);
        queue_block(32'd8);
        queue_block(32'd1);
        drain();

        // zero sector count rejects everything
        write_reg(sclt_pkg::REG_SECTOR_COUNT, 32'd0);
        queue_block(32'd0);
        queue_block(32'd1);
        queue_block(32'hFFFF_FFFF);
        drain();

        // full range; a write to the unused address must change nothing
        write_reg(sclt_pkg::REG_SECTOR_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'd5);
        queue_block(32'hFFFF_FFFE);
        queue_block(32'hFFFF_FFFF);
        queue_block(32'd7);
        queue_block(32'h8000_0000);
        drain();

        write_reg(sclt_pkg::REG_SECTOR_COUNT, 32'd1);
        queue_block(32'd1);
        queue_block(32'd0);
        drain();

        write_reg(sclt_pkg::REG_SECTOR_COUNT, 32'd2);
        queue_block(32'd1);
        queue_block(32'd2);
        drain();

        for (ph = 0; ph < 16; ph++)
        begin
            case (ph % 6)
                0:       count = 32'd1760;
                1:       count = $urandom_range(2, 20);
                2:       count = 32'd9;
                3:       count = 32'hFFFF_FFFF;
                4:       count = $urandom() | 32'h100;
                default: count = $urandom_range(21, 5000);
            endcase
            write_reg(sclt_pkg::REG_SECTOR_COUNT, count);
            send_pace = pace_t'($urandom_range(0, 2));
            recv_pace = pace_t'($urandom_range(0, 2));
            // a working set a bit larger than the cache keeps hits and evictions busy
            for (k = 0; k < POOL_SIZE; k++)
                tag_pool[k] = $urandom_range(1, count - 1);
            n = $urandom_range(70, 120);
            for (k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    blk = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (r < 82)
                    blk = $urandom();
                else if (r < 88)
                    blk = '0;
                else if (r < 94)
                    blk = count + $urandom_range(0, 2) - 1;
                else
                    blk = 32'hFFFF_FFFF;
                queue_block(blk);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
